>>> rtl/pkw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Pinwheel key generator package
// Field widths, command codes, wheel indices and the per-wheel control
// bundle shared by the wheel cells and the core.
// ----------------------------------------------------------------------------
package pkw_pkg;

    // Request and result field widths.
    localparam int CMD_W   = 2;
    localparam int WHEEL_W = 4;
    localparam int NUM_W   = 7;
    localparam int KEY_W   = 5;

    // Wheel set: five psi, two motors, five chi.
    localparam int WHEEL_COUNT = 12;
    localparam int PSI_BASE    = 0;
    localparam int MOTOR37     = 5;
    localparam int MOTOR61     = 6;
    localparam int CHI_BASE    = 7;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_WRITE_PIN = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET_LEN   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SET_POS   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_STEP      = 2'd3;

    // Update controls for one wheel in one cycle.
    typedef struct packed {
        logic             write_pin;
        logic             set_len;
        logic             set_pos;
        logic             advance;
        logic [NUM_W-1:0] number;
        logic             pin_value;
    } wheel_ctrl_t;

endpackage
`default_nettype wire

>>> rtl/pkw_cmd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Pinwheel command channel
// Valid/ready channel that carries one load or step request.
// ----------------------------------------------------------------------------
interface pkw_cmd_if import pkw_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [WHEEL_W-1:0] wheel;
    logic [NUM_W-1:0]   number;
    logic               pin_value;

    modport source (output valid, output cmd, output wheel, output number,
                    output pin_value, input ready);
    modport sink   (input valid, input cmd, input wheel, input number,
                    input pin_value, output ready);

endinterface
`default_nettype wire

>>> rtl/pkw_key_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Pinwheel key channel
// Valid/ready channel that carries one key result per request.
// ----------------------------------------------------------------------------
interface pkw_key_if import pkw_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] key;
    logic             key_valid;

    modport source (output valid, output key, output key_valid, input ready);
    modport sink   (input valid, input key, input key_valid, output ready);

endinterface
`default_nettype wire

>>> rtl/pinwheel_key_generator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Pinwheel key generator core
// Twelve-wheel Lorenz-style keystream generator with load and step requests.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_ch takes one request per handshake: write a pin, set a wheel length,
//   set a wheel position, or step. Every request gives exactly one result on
//   key_ch. A step result carries the five-bit chi XOR psi key with key_valid
//   set; a load result carries key 0 with key_valid clear.
// Timing:
//   A request is captured in an input register at its handshake edge and is
//   processed once the result register is free, which updates the wheels and
//   loads the result register. Throughput is one request per cycle while
//   key_ch is not stalled; the combinational wheel update loop (pin select,
//   increment and wrap compare, motor gating) sets that figure.
// Stall:
//   While key_ch is stalled the result register holds; one more request can
//   wait in the input register, after which cmd_ch deasserts ready.
// Reset:
//   rst_n clears both registers' valid flags and sets every wheel to all-zero
//   pins, length one and position zero.
// ----------------------------------------------------------------------------
module pinwheel_key_generator_core
    import pkw_pkg::*;
#(
    parameter int MAX_WHEEL_LEN = 64
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    pkw_cmd_if.sink    cmd_ch,
    pkw_key_if.source  key_ch
);

    // Input register.
    logic               in_valid_reg, in_valid_next;
    logic [CMD_W-1:0]   cmd_reg;
    logic [WHEEL_W-1:0] wheel_reg;
    logic [NUM_W-1:0]   number_reg;
    logic               pin_value_reg;

    // Result register.
    logic               out_valid_reg, out_valid_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic               key_valid_reg, key_valid_next;

    logic               proc;
    logic               is_step;
    logic               m37_pin_new;

    wheel_ctrl_t        ctrl [WHEEL_COUNT];
    logic               pin_cur [WHEEL_COUNT];
    logic               pin_adv [WHEEL_COUNT];

    // Handshake: process the held request when the result register frees up.
    assign proc         = in_valid_reg && (!out_valid_reg || key_ch.ready);
    assign cmd_ch.ready = !in_valid_reg || proc;
    assign is_step      = (cmd_reg == CMD_STEP);

    assign in_valid_next  = cmd_ch.ready ? cmd_ch.valid : in_valid_reg;
    assign out_valid_next = proc ? 1'b1 : (key_ch.ready ? 1'b0 : out_valid_reg);

    // The 37-motor pin seen by the psi gate, after its own possible advance.
    assign m37_pin_new = pin_adv[MOTOR61] ? pin_adv[MOTOR37] : pin_cur[MOTOR37];

    // Per-wheel load and advance controls.
    always_comb
    begin
        for (int i = 0; i < WHEEL_COUNT; i++)
        begin
            ctrl[i].number    = number_reg;
            ctrl[i].pin_value = pin_value_reg;
            ctrl[i].write_pin = proc && (cmd_reg == CMD_WRITE_PIN) &&
                                (wheel_reg == WHEEL_W'(i));
            ctrl[i].set_len   = proc && (cmd_reg == CMD_SET_LEN) &&
                                (wheel_reg == WHEEL_W'(i));
            ctrl[i].set_pos   = proc && (cmd_reg == CMD_SET_POS) &&
                                (wheel_reg == WHEEL_W'(i));
            if (i >= CHI_BASE || i == MOTOR61)
            begin
                ctrl[i].advance = proc && is_step;
            end
            else if (i == MOTOR37)
            begin
                ctrl[i].advance = proc && is_step && pin_adv[MOTOR61];
            end
            else
            begin
                ctrl[i].advance = proc && is_step && !m37_pin_new;
            end
        end
    end

    // Key from the pins under the current positions.
    always_comb
    begin
        key_next = '0;
        if (is_step)
        begin
            for (int i = 0; i < KEY_W; i++)
            begin
                key_next[i] = pin_cur[CHI_BASE + i] ^ pin_cur[PSI_BASE + i];
            end
        end
        key_valid_next = is_step;
    end

    // Wheel cells.
    for (genvar g = 0; g < WHEEL_COUNT; g++)
    begin : g_wheel
        pkw_wheel #(
            .MAX_LEN (MAX_WHEEL_LEN)
        ) u_wheel (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl[g]),
            .pin_cur (pin_cur[g]),
            .pin_adv (pin_adv[g])
        );
    end

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd_ch.ready && cmd_ch.valid)
        begin
            cmd_reg       <= cmd_ch.cmd;
            wheel_reg     <= cmd_ch.wheel;
            number_reg    <= cmd_ch.number;
            pin_value_reg <= cmd_ch.pin_value;
        end
        if (proc)
        begin
            key_reg       <= key_next;
            key_valid_reg <= key_valid_next;
        end
    end

    assign key_ch.valid     = out_valid_reg;
    assign key_ch.key       = key_reg;
    assign key_ch.key_valid = key_valid_reg;

endmodule
`default_nettype wire

>>> rtl/pkw_wheel.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Pinwheel wheel cell
// Holds one wheel's pins, length and position. Presents the pin under the
// current position and the pin under the advanced position, and applies
// one load or advance per cycle.
// ----------------------------------------------------------------------------
module pkw_wheel
    import pkw_pkg::*;
#(
    parameter int MAX_LEN = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire wheel_ctrl_t ctrl,
    output logic             pin_cur,
    output logic             pin_adv
);

    localparam int POS_W = $clog2(MAX_LEN);
    localparam int LEN_W = $clog2(MAX_LEN + 1);

    logic [MAX_LEN-1:0] pins_reg, pins_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [POS_W-1:0]   pos_reg, pos_next;

    logic [LEN_W-1:0]   pos_plus;
    logic [POS_W-1:0]   pos_adv;
    logic [LEN_W-1:0]   len_load;

    // Advanced position, wrapping at the wheel length.
    assign pos_plus = LEN_W'(pos_reg) + LEN_W'(1);
    assign pos_adv  = (pos_plus >= len_reg) ? '0 : pos_plus[POS_W-1:0];

    assign pin_cur = pins_reg[pos_reg];
    assign pin_adv = pins_reg[pos_adv];

    // Requested length, saturated to the legal range.
    always_comb
    begin
        if (ctrl.number == '0)
        begin
            len_load = LEN_W'(1);
        end
        else if (ctrl.number > NUM_W'(MAX_LEN))
        begin
            len_load = LEN_W'(MAX_LEN);
        end
        else
        begin
            len_load = ctrl.number[LEN_W-1:0];
        end
    end

    // Next state for the load and advance operations.
    always_comb
    begin
        pins_next = pins_reg;
        len_next  = len_reg;
        pos_next  = pos_reg;
        if (ctrl.write_pin)
        begin
            if (ctrl.number < NUM_W'(MAX_LEN))
            begin
                pins_next[ctrl.number[POS_W-1:0]] = ctrl.pin_value;
            end
        end
        else if (ctrl.set_len)
        begin
            len_next = len_load;
            if (LEN_W'(pos_reg) >= len_load)
            begin
                pos_next = '0;
            end
        end
        else if (ctrl.set_pos)
        begin
            if (ctrl.number < NUM_W'(len_reg))
            begin
                pos_next = ctrl.number[POS_W-1:0];
            end
            else
            begin
                pos_next = '0;
            end
        end
        else if (ctrl.advance)
        begin
            pos_next = pos_adv;
        end
    end

    // Wheel state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pins_reg <= '0;
            len_reg  <= LEN_W'(1);
            pos_reg  <= '0;
        end
        else
        begin
            pins_reg <= pins_next;
            len_reg  <= len_next;
            pos_reg  <= pos_next;
        end
    end

endmodule
`default_nettype wire

>>> tb/pinwheel_key_generator_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pinwheel key generator result checker
// Watches the request and key channels of the core. For every accepted
// request it updates its own copy of the twelve wheels and queues the key
// result that request must give. It compares every accepted key result,
// field by field, against the oldest queued one.
// ----------------------------------------------------------------------------
module pinwheel_key_generator_core_checker
    import pkw_pkg::*;
#(
    parameter int MAX_LEN = 64
)
(
    input  logic clk,
    input  logic rst_n,
    pkw_cmd_if   cmd_mon,
    pkw_key_if   key_mon,
    output int   fail_count,
    output int   keys_outstanding,
    output int   steps_seen,
    output int   loads_seen
);

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             key_valid;
    } key_result_t;

    // Shadow copy of the wheels.
    logic [63:0]      wheel_pins [WHEEL_COUNT];
    logic [NUM_W-1:0] wheel_len  [WHEEL_COUNT];
    logic [5:0]       wheel_pos  [WHEEL_COUNT];

    key_result_t pending_keys [$];
    key_result_t want;
    key_result_t got;
    key_result_t predicted;
    int          mismatches;
    int          step_total;
    int          load_total;

    // Pin under the read position of one wheel.
    function automatic logic pin_now(input int w);
        return wheel_pins[w][wheel_pos[w]];
    endfunction

    // Move one wheel on by one position, wrapping at its length.
    function automatic void wheel_advance(input int w);
        logic [NUM_W-1:0] nxt;
        nxt = {1'b0, wheel_pos[w]} + 7'd1;
        if (nxt >= wheel_len[w])
            nxt = '0;
        wheel_pos[w] = nxt[5:0];
    endfunction

    // Apply one request to the shadow wheels and return the key it gives.
    function automatic key_result_t apply_request(
        input logic [CMD_W-1:0]   c,
        input logic [WHEEL_W-1:0] w,
        input logic [NUM_W-1:0]   n,
        input logic               p
    );
        key_result_t      r;
        logic [NUM_W-1:0] len;
        r = '0;
        if (c == CMD_STEP)
        begin
            for (int i = 0; i < KEY_W; i++)
                r.key[i] = pin_now(CHI_BASE + i) ^ pin_now(PSI_BASE + i);
            r.key_valid = 1'b1;
            for (int i = 0; i < KEY_W; i++)
                wheel_advance(CHI_BASE + i);
            wheel_advance(MOTOR61);
            if (pin_now(MOTOR61))
                wheel_advance(MOTOR37);
            // The psi wheels only move while the 37-motor shows a zero pin.
            if (!pin_now(MOTOR37))
            begin
                for (int i = 0; i < KEY_W; i++)
                    wheel_advance(PSI_BASE + i);
            end
        end
        else if (w < WHEEL_COUNT)
        begin
            case (c)
                CMD_WRITE_PIN:
                begin
                    if (n < MAX_LEN && n < 64)
                        wheel_pins[w][n[5:0]] = p;
                end
                CMD_SET_LEN:
                begin
                    len = n;
                    if (len < 1)
                        len = NUM_W'(1);
                    if (len > MAX_LEN)
                        len = NUM_W'(MAX_LEN);
                    wheel_len[w] = len;
                    if ({1'b0, wheel_pos[w]} >= len)
                        wheel_pos[w] = '0;
                end
                default:
                begin
                    if (n < wheel_len[w])
                        wheel_pos[w] = n[5:0];
                    else
                        wheel_pos[w] = '0;
                end
            endcase
        end
        return r;
    endfunction

    // Count a failure; only the first few are described.
    function automatic void note_failure(input string what, input key_result_t e,
                                         input key_result_t a);
        mismatches++;
        if (mismatches <= 10)
            $display("%t: mismatch (%s): want key=%02h valid=%0d got key=%02h valid=%0d",
                     $realtime, what, e.key, e.key_valid, a.key, a.key_valid);
    endfunction

    // Result check first, then prediction: a result never belongs to a
    // request accepted at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WHEEL_COUNT; i++)
            begin
                wheel_pins[i] = '0;
                wheel_len[i]  = 7'd1;
                wheel_pos[i]  = '0;
            end
            pending_keys.delete();
            mismatches       = 0;
            step_total       = 0;
            load_total       = 0;
            fail_count       <= 0;
            keys_outstanding <= 0;
            steps_seen       <= 0;
            loads_seen       <= 0;
        end
        else
        begin
            if (key_mon.valid && key_mon.ready)
            begin
                got.key       = key_mon.key;
                got.key_valid = key_mon.key_valid;
                if (pending_keys.size() == 0)
                    note_failure("no request outstanding", '0, got);
                else
                begin
                    want = pending_keys.pop_front();
                    if (got.key !== want.key)
                        note_failure("key", want, got);
                    else if (got.key_valid !== want.key_valid)
                        note_failure("key_valid", want, got);
                end
            end
            if (cmd_mon.valid && cmd_mon.ready)
            begin
                if (cmd_mon.cmd == CMD_STEP)
                    step_total++;
                else
                    load_total++;
                predicted = apply_request(cmd_mon.cmd, cmd_mon.wheel,
                                          cmd_mon.number, cmd_mon.pin_value);
                pending_keys.insert(pending_keys.size(), predicted);
            end
            fail_count       <= mismatches;
            keys_outstanding <= pending_keys.size();
            steps_seen       <= step_total;
            loads_seen       <= load_total;
        end
    end

endmodule

>>> tb/pinwheel_key_generator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pinwheel key generator testbench
// Drives load and step requests into the core: a directed opening on the
// saturation, wrap and ignored-request cases, then random phases that load a
// few wheels and run the keystream. Both channels idle at random. A checker
// beside the core predicts and compares every key result.
// ----------------------------------------------------------------------------
module pinwheel_key_generator_core_tb;
    import pkw_pkg::*;

    localparam int MAX_LEN     = 64;
    localparam int ITEM_TARGET = 1650;
    localparam int CYCLE_LIMIT = 500000;

    logic clk;
    logic rst_n;
    logic calm;
    int   cycles;
    int   sent_count;
    int   stall_left;
    int   chk_fails;
    int   chk_outstanding;
    int   chk_steps;
    int   chk_loads;

    pkw_cmd_if cmd_ch ();
    pkw_key_if key_ch ();

    pinwheel_key_generator_core #(
        .MAX_WHEEL_LEN(MAX_LEN)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd_ch(cmd_ch),
        .key_ch(key_ch)
    );

    pinwheel_key_generator_core_checker #(
        .MAX_LEN(MAX_LEN)
    ) checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_mon         (cmd_ch),
        .key_mon         (key_ch),
        .fail_count      (chk_fails),
        .keys_outstanding(chk_outstanding),
        .steps_seen      (chk_steps),
        .loads_seen      (chk_loads)
    );

    // Clock.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("pinwheel_key_generator_core_tb: errors");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Key channel back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_ch.ready <= 1'b0;
            stall_left   <= 0;
        end
        else if (stall_left > 0)
        begin
            key_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else
        begin
            key_ch.ready <= 1'b1;
            if (!calm && $urandom_range(0, 99) < 30)
                stall_left <= pick_gap();
        end
    end

    // Present one request and hold it until the core takes it.
    task automatic send_req(input logic [CMD_W-1:0] c, input logic [WHEEL_W-1:0] w,
                            input logic [NUM_W-1:0] n, input logic p);
        int gap;
        cmd_ch.valid     <= 1'b1;
        cmd_ch.cmd       <= c;
        cmd_ch.wheel     <= w;
        cmd_ch.number    <= n;
        cmd_ch.pin_value <= p;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        sent_count++;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Length request value: extremes and out-of-range values now and then.
    function automatic logic [NUM_W-1:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return NUM_W'(MAX_LEN);
        if (r < 14)
            return 7'd2;
        if (r < 18)
            return NUM_W'($urandom_range(0, 1));
        if (r < 22)
            return NUM_W'($urandom_range(65, 127));
        return NUM_W'($urandom_range(2, MAX_LEN));
    endfunction

    // One random phase: reload a few wheels, maybe some noise, then steps.
    task automatic run_phase();
        int               w;
        int               eff;
        int               n_pins;
        logic [NUM_W-1:0] len;
        logic [NUM_W-1:0] idx;
        calm <= ($urandom_range(0, 3) == 0);
        repeat ($urandom_range(1, 4))
        begin
            w   = $urandom_range(0, WHEEL_COUNT - 1);
            len = pick_len();
            eff = (len < 1) ? 1 : ((len > MAX_LEN) ? MAX_LEN : int'(len));
            send_req(CMD_SET_LEN, WHEEL_W'(w), len, 1'b0);
            n_pins = $urandom_range(0, (eff < 16) ? eff : 16);
            repeat (n_pins)
            begin
                if ($urandom_range(0, 99) < 8)
                    idx = NUM_W'($urandom_range(0, 127));
                else
                    idx = NUM_W'($urandom_range(0, eff - 1));
                send_req(CMD_WRITE_PIN, WHEEL_W'(w), idx, 1'($urandom_range(0, 1)));
            end
            send_req(CMD_SET_POS, WHEEL_W'(w), NUM_W'($urandom_range(0, eff + 2)), 1'b0);
        end
        // Fully random requests, including out-of-range wheels and numbers.
        if ($urandom_range(0, 99) < 15)
        begin
            repeat ($urandom_range(1, 5))
                send_req(CMD_W'($urandom_range(0, 3)), WHEEL_W'($urandom_range(0, 15)),
                         NUM_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
        end
        repeat ($urandom_range(5, 40))
            send_req(CMD_STEP, WHEEL_W'($urandom_range(0, 15)),
                     NUM_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        calm             <= 1'b0;
        cycles           <= 0;
        sent_count        = 0;
        cmd_ch.valid     <= 1'b0;
        cmd_ch.cmd       <= CMD_WRITE_PIN;
        cmd_ch.wheel     <= '0;
        cmd_ch.number    <= '0;
        cmd_ch.pin_value <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening.
        send_req(CMD_STEP, 4'd0, 7'd0, 1'b0);                       // key of the reset state
        send_req(CMD_SET_LEN, WHEEL_W'(CHI_BASE), 7'd0, 1'b0);      // length saturates to one
        send_req(CMD_SET_LEN, WHEEL_W'(CHI_BASE), 7'd127, 1'b0);    // length saturates to max
        send_req(CMD_WRITE_PIN, WHEEL_W'(CHI_BASE), 7'd63, 1'b1);   // last pin of a full wheel
        send_req(CMD_SET_POS, WHEEL_W'(CHI_BASE), 7'd63, 1'b0);
        send_req(CMD_STEP, 4'd15, 7'd127, 1'b1);                    // step ignores its fields
        send_req(CMD_WRITE_PIN, WHEEL_W'(CHI_BASE), 7'd100, 1'b1);  // pin index out of range
        send_req(CMD_WRITE_PIN, 4'd15, 7'd0, 1'b1);                 // wheel out of range
        send_req(CMD_SET_LEN, 4'd12, 7'd5, 1'b0);
        send_req(CMD_SET_POS, 4'd14, 7'd3, 1'b0);
        send_req(CMD_SET_LEN, WHEEL_W'(MOTOR61), 7'd2, 1'b0);
        send_req(CMD_WRITE_PIN, WHEEL_W'(MOTOR61), 7'd1, 1'b1);
        send_req(CMD_SET_LEN, WHEEL_W'(MOTOR37), 7'd3, 1'b0);
        send_req(CMD_SET_POS, WHEEL_W'(MOTOR37), 7'd3, 1'b0);       // position not below length
        send_req(CMD_WRITE_PIN, WHEEL_W'(MOTOR37), 7'd1, 1'b1);
        send_req(CMD_SET_POS, WHEEL_W'(PSI_BASE), 7'd64, 1'b0);
        send_req(CMD_SET_LEN, WHEEL_W'(PSI_BASE), 7'd64, 1'b0);
        send_req(CMD_WRITE_PIN, WHEEL_W'(PSI_BASE), 7'd0, 1'b1);
        send_req(CMD_WRITE_PIN, WHEEL_W'(PSI_BASE), 7'd2, 1'b1);
        send_req(CMD_SET_POS, WHEEL_W'(CHI_BASE), 7'd10, 1'b0);
        send_req(CMD_SET_LEN, WHEEL_W'(CHI_BASE), 7'd5, 1'b0);      // shrink past the position
        send_req(CMD_WRITE_PIN, 4'd11, 7'd127, 1'b1);
        repeat (4)
            send_req(CMD_STEP, 4'd0, 7'd0, 1'b0);

        // Random phases.
        while (sent_count < ITEM_TARGET)
            run_phase();

        // Drain; one edge first so the checker has counted the last request.
        cmd_ch.valid <= 1'b0;
        calm         <= 1'b1;
        @(posedge clk);
        while (chk_outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d requests: %0d steps and %0d loads, idling on both channels.",
                 sent_count, chk_steps, chk_loads);
        $display("Mismatches: %0d, results still outstanding: %0d.",
                 chk_fails, chk_outstanding);
        if (chk_fails == 0 && chk_outstanding == 0)
            $display("pinwheel_key_generator_core_tb: clean");
        else
            $display("pinwheel_key_generator_core_tb: errors");
        $finish;
    end

endmodule
